### rtl/button_click_event_detector_top_assert.svh
// Assertion macros used by the button click detector top level.
`ifndef BUTTON_CLICK_EVENT_DETECTOR_TOP_ASSERT_SVH
`define BUTTON_CLICK_EVENT_DETECTOR_TOP_ASSERT_SVH

// Check a property on clk_i, skipped while rst_ni is low.
`define BCED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check a property on clk_i at every edge, reset included.
`define BCED_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/bced_pkg.sv
// Types and constants of the button click detector.
package bced_pkg;

  localparam int unsigned APB_AW = 5;

  typedef enum logic [2:0] {
    REG_DEBOUNCE = 3'd0,
    REG_SHORT    = 3'd1,
    REG_LONG     = 3'd2,
    REG_ACTIVE   = 3'd3,
    REG_INVERT   = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    PS_IDLE    = 3'd0,
    PS_PRESSED = 3'd1,
    PS_WAIT    = 3'd2,
    PS_AGAIN   = 3'd3,
    PS_HOLD    = 3'd5
  } press_e;

  typedef enum logic [2:0] {
    EV_DOWN       = 3'd0,
    EV_UP         = 3'd1,
    EV_SINGLE     = 3'd2,
    EV_DOUBLE     = 3'd3,
    EV_LONG_START = 3'd4,
    EV_LONG_HOLD  = 3'd5,
    EV_NONE       = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_SHORT  = 2'd1,
    ACT_DOUBLE = 2'd2,
    ACT_LONG   = 2'd3
  } act_e;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_INIT = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [4:0] button_index;
    logic       raw_level;
  } in_item_t;

  typedef struct packed {
    logic [4:0] button_number;
    logic [2:0] event_code;
    logic [1:0] action;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  debounce_ticks;
    logic [15:0] short_ticks;
    logic [15:0] long_ticks;
    logic        press_polarity;
    logic [31:0] invert_mask;
  } cfg_t;

  typedef struct packed {
    press_e      press_state;
    logic [15:0] tick_count;
    logic [3:0]  repeat_count;
    logic [2:0]  debounce_count;
    logic        stable_level;
    event_e      last_event;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    press_state:    PS_IDLE,
    tick_count:     16'd0,
    repeat_count:   4'd0,
    debounce_count: 3'd0,
    stable_level:   1'b0,
    last_event:     EV_NONE
  };

  localparam cfg_t CFG_RESET = '{
    debounce_ticks: 3'd3,
    short_ticks:    16'd60,
    long_ticks:     16'd200,
    press_polarity: 1'b0,
    invert_mask:    32'd0
  };

endpackage

### rtl/bced_regs.sv
// APB register file holding the detector configuration.
module bced_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bced_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output bced_pkg::cfg_t             cfg_o
);
  import bced_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_DEBOUNCE: cfg_d.debounce_ticks = pwdata[2:0];
        REG_SHORT:    cfg_d.short_ticks    = pwdata[15:0];
        REG_LONG:     cfg_d.long_ticks     = pwdata[15:0];
        REG_ACTIVE:   cfg_d.press_polarity = pwdata[0];
        REG_INVERT:   cfg_d.invert_mask    = pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEBOUNCE: prdata = {29'd0, cfg_q.debounce_ticks};
      REG_SHORT:    prdata = {16'd0, cfg_q.short_ticks};
      REG_LONG:     prdata = {16'd0, cfg_q.long_ticks};
      REG_ACTIVE:   prdata = {31'd0, cfg_q.press_polarity};
      REG_INVERT:   prdata = cfg_q.invert_mask;
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/bced_state_mem.sv
// Per-button state memory with registered read, valid bits and write forwarding.
module bced_state_mem #(
  parameter int unsigned BUTTONS = 32,
  parameter int unsigned IDX_W   = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [IDX_W-1:0]    rd_addr_i,
  output bced_pkg::entry_t    rd_data_o,
  input  logic                wr_en_i,
  input  logic [IDX_W-1:0]    wr_addr_i,
  input  bced_pkg::entry_t    wr_data_i
);
  import bced_pkg::*;

  entry_t             mem [BUTTONS];
  logic [BUTTONS-1:0] valid_q;
  entry_t             rd_q;
  logic               rd_valid_q;
  logic [IDX_W-1:0]   rd_addr_q;
  entry_t             fwd_q;
  logic [IDX_W-1:0]   fwd_addr_q;
  logic               fwd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
    if (wr_en_i) begin
      fwd_q      <= wr_data_i;
      fwd_addr_q <= wr_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      rd_addr_q   <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
        fwd_valid_q        <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
        rd_addr_q  <= rd_addr_i;
      end
    end
  end

  // The forward register always holds the latest write, so it wins on a match.
  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == rd_addr_q)) begin
      rd_data_o = fwd_q;
    end else if (rd_valid_q) begin
      rd_data_o = rd_q;
    end else begin
      rd_data_o = ENTRY_RESET;
    end
  end

endmodule

### rtl/bced_update.sv
// Debounce and press state machine step for one button entry.
module bced_update (
  input  bced_pkg::entry_t cur_i,
  input  logic             init_i,
  input  logic             level_i,
  input  bced_pkg::cfg_t   cfg_i,
  output bced_pkg::entry_t nxt_o,
  output bced_pkg::act_e   act_o
);
  import bced_pkg::*;

  entry_t     nxt;
  logic [2:0] dc_inc;
  logic [3:0] rep_inc;
  logic       pressed;

  assign dc_inc  = cur_i.debounce_count + 3'd1;
  assign rep_inc = cur_i.repeat_count + 4'd1;

  always_comb begin
    nxt     = cur_i;
    act_o   = ACT_NONE;
    pressed = 1'b0;
    if (init_i) begin
      nxt              = ENTRY_RESET;
      nxt.stable_level = level_i;
    end else begin
      if (cur_i.press_state != PS_IDLE) begin
        nxt.tick_count = cur_i.tick_count + 16'd1;
      end
      if (level_i != cur_i.stable_level) begin
        if (dc_inc >= cfg_i.debounce_ticks) begin
          nxt.stable_level   = level_i;
          nxt.debounce_count = 3'd0;
        end else begin
          nxt.debounce_count = dc_inc;
        end
      end else begin
        nxt.debounce_count = 3'd0;
      end
      pressed = (nxt.stable_level == cfg_i.press_polarity);

      unique case (cur_i.press_state)
        PS_IDLE: begin
          if (pressed) begin
            nxt.last_event   = EV_DOWN;
            nxt.tick_count   = 16'd0;
            nxt.repeat_count = 4'd1;
            nxt.press_state  = PS_PRESSED;
          end else begin
            nxt.last_event = EV_NONE;
          end
        end
        PS_PRESSED: begin
          if (!pressed) begin
            nxt.last_event  = EV_UP;
            nxt.tick_count  = 16'd0;
            nxt.press_state = PS_WAIT;
          end else if (nxt.tick_count > cfg_i.long_ticks) begin
            nxt.last_event  = EV_LONG_START;
            act_o           = ACT_LONG;
            nxt.press_state = PS_HOLD;
          end
        end
        PS_WAIT: begin
          if (pressed) begin
            nxt.last_event   = EV_DOWN;
            nxt.repeat_count = rep_inc;
            if (rep_inc == 4'd2) begin
              act_o = ACT_DOUBLE;
            end
            nxt.tick_count  = 16'd0;
            nxt.press_state = PS_AGAIN;
          end else if (nxt.tick_count > cfg_i.short_ticks) begin
            if (cur_i.repeat_count == 4'd1) begin
              nxt.last_event = EV_SINGLE;
              act_o          = ACT_SHORT;
            end else if (cur_i.repeat_count == 4'd2) begin
              nxt.last_event = EV_DOUBLE;
            end
            nxt.press_state = PS_IDLE;
          end
        end
        PS_AGAIN: begin
          if (!pressed) begin
            nxt.last_event = EV_UP;
            if (nxt.tick_count < cfg_i.short_ticks) begin
              nxt.tick_count  = 16'd0;
              nxt.press_state = PS_WAIT;
            end else begin
              nxt.press_state = PS_IDLE;
            end
          end
        end
        PS_HOLD: begin
          if (pressed) begin
            nxt.last_event = EV_LONG_HOLD;
          end else begin
            nxt.last_event  = EV_UP;
            nxt.press_state = PS_IDLE;
          end
        end
        default: ;
      endcase
    end
    nxt_o = nxt;
  end

endmodule

### rtl/button_click_event_detector_top.sv
// Top level of the multi-button click, double click and long press detector.
//
//  port group        | dir | handshake                      | payload
//  ------------------+-----+--------------------------------+----------------------
//  sample / init in  | in  | in_valid_i / in_ready_o        | in_data_i  (in_item_t)
//  event result out  | out | out_valid_o / out_ready_i      | out_data_o (out_item_t)
//  configuration     | in  | psel, penable, pwrite / pready | paddr, pwdata, prdata
//
// One item per cycle sustained while the output is not stalled.
// Stage one reads the button entry from the single state memory (registered
// read); stage two updates it, writes it back and loads the output
// register. A write forward register covers back-to-back items on one button.
// Reset clears control state and the per-entry valid bits; no clearing pass.
// With the output stalled, one item may still enter and wait in stage two.
module button_click_event_detector_top #(
  parameter int unsigned BUTTONS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bced_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bced_pkg::out_item_t         out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bced_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import bced_pkg::*;

  localparam int unsigned IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  cfg_t       cfg;
  logic       in_fire;
  logic       s1_valid_q;
  in_item_t   s1_item_q;
  logic       s1_advance;
  logic       s1_in_range;
  logic       s1_level;
  entry_t     cur_entry;
  entry_t     nxt_entry;
  act_e       nxt_act;
  logic       mem_wr_en;
  logic       out_valid_q;
  out_item_t  out_q;
  out_item_t  out_d;

  bced_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_fire    = in_valid_i && in_ready_o;

  assign s1_in_range = ({1'b0, s1_item_q.button_index} < 6'(BUTTONS));
  assign s1_level    = s1_item_q.raw_level ^ cfg.invert_mask[s1_item_q.button_index];
  assign mem_wr_en   = s1_advance && s1_in_range;

  bced_state_mem #(
    .BUTTONS (BUTTONS),
    .IDX_W   (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_data_i.button_index[IDX_W-1:0]),
    .rd_data_o (cur_entry),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (s1_item_q.button_index[IDX_W-1:0]),
    .wr_data_i (nxt_entry)
  );

  bced_update u_update (
    .cur_i   (cur_entry),
    .init_i  (s1_item_q.opcode == OP_INIT),
    .level_i (s1_level),
    .cfg_i   (cfg),
    .nxt_o   (nxt_entry),
    .act_o   (nxt_act)
  );

  always_comb begin
    out_d.button_number = s1_item_q.button_index;
    if (s1_in_range) begin
      out_d.event_code = nxt_entry.last_event;
      out_d.action     = nxt_act;
    end else begin
      out_d.event_code = EV_NONE;
      out_d.action     = ACT_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_data_i;
    end
    if (s1_advance) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `include "button_click_event_detector_top_assert.svh"

  `BCED_ASSERT(a_accept_reaches_s1, in_fire |=> s1_valid_q, "accepted transaction lost")
  `BCED_ASSERT(a_stall_cause,
      !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i,
      "input stalled without cause")
  `BCED_ASSERT(a_long_event,
      out_valid_o && out_data_o.action == ACT_LONG |-> out_data_o.event_code == EV_LONG_START,
      "long action without long start")
  `BCED_ASSERT(a_short_event,
      out_valid_o && out_data_o.action == ACT_SHORT |-> out_data_o.event_code == EV_SINGLE,
      "short action without single event")
  `BCED_ASSERT_ALWAYS(a_no_stray_write,
      mem_wr_en |-> s1_valid_q && s1_in_range,
      "state write without a live in-range item")

endmodule

### tb/tb_button_click_event_detector_top.sv
// Testbench for the multi-button click, double click and long press detector.
`timescale 1ns / 1ps

module tb_button_click_event_detector_top;
  import bced_pkg::*;

  localparam int CYCLE_NS  = 12;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [APB_AW-1:0]   paddr       = '0;
  logic [31:0]         pwdata      = '0;
  logic [31:0]         prdata;
  logic                pready;

  button_click_event_detector_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #(CYCLE_NS / 2) clk_i = 1'b1;
    #(CYCLE_NS / 2) clk_i = 1'b0;
  end

  // Shadow copy of the configuration registers.
  logic [2:0]  dbnc_ticks;
  logic [15:0] short_lim;
  logic [15:0] long_lim;
  logic        press_level;
  logic [31:0] invert_bits;

  // Shadow copy of the per-button state.
  press_e      btn_state   [32];
  logic [15:0] btn_ticks   [32];
  logic [3:0]  btn_repeats [32];
  logic [2:0]  btn_dbnc    [32];
  logic        btn_level   [32];
  event_e      btn_event   [32];

  out_item_t pending_events[$];
  int        gap_pct = 37;
  int        mismatches = 0;
  int        events_seen = 0;
  int        items_sent = 0;
  int        settings_loaded = 0;

  // Gesture generator: raw level and remaining run length per button.
  logic      drive_level [32];
  int        run_left    [32];
  int        focus       [3];

  typedef struct {
    logic      is_write;
    reg_idx_e  reg_sel;
    logic [31:0] value;
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } step_row_t;

  step_row_t script[$];

  function automatic void clear_buttons();
    for (int b = 0; b < 32; b++) begin
      btn_state[b]   = PS_IDLE;
      btn_ticks[b]   = '0;
      btn_repeats[b] = '0;
      btn_dbnc[b]    = '0;
      btn_level[b]   = 1'b0;
      btn_event[b]   = EV_NONE;
      drive_level[b] = 1'b0;
      run_left[b]    = 0;
    end
    dbnc_ticks  = CFG_RESET.debounce_ticks;
    short_lim   = CFG_RESET.short_ticks;
    long_lim    = CFG_RESET.long_ticks;
    press_level = CFG_RESET.press_polarity;
    invert_bits = CFG_RESET.invert_mask;
  endfunction

  // Work out the result of one transaction and advance the shadow state.
  function automatic out_item_t next_button_event(input in_item_t it);
    int        b;
    logic      lvl;
    logic      pressed;
    act_e      act;
    out_item_t r;
    b = it.button_index;
    act = ACT_NONE;
    r.button_number = it.button_index;
    r.event_code    = EV_NONE;
    r.action        = ACT_NONE;
    lvl = it.raw_level ^ invert_bits[b];
    if (it.opcode == OP_INIT) begin
      btn_state[b]   = PS_IDLE;
      btn_ticks[b]   = '0;
      btn_repeats[b] = '0;
      btn_dbnc[b]    = '0;
      btn_level[b]   = lvl;
      btn_event[b]   = EV_NONE;
      return r;
    end
    if (btn_state[b] != PS_IDLE) btn_ticks[b] = btn_ticks[b] + 16'd1;
    if (lvl != btn_level[b]) begin
      btn_dbnc[b] = btn_dbnc[b] + 3'd1;
      if (btn_dbnc[b] >= dbnc_ticks) begin
        btn_level[b] = lvl;
        btn_dbnc[b]  = '0;
      end
    end else begin
      btn_dbnc[b] = '0;
    end
    pressed = (btn_level[b] == press_level);
    case (btn_state[b])
      PS_IDLE: begin
        if (pressed) begin
          btn_event[b]   = EV_DOWN;
          btn_ticks[b]   = '0;
          btn_repeats[b] = 4'd1;
          btn_state[b]   = PS_PRESSED;
        end else begin
          btn_event[b] = EV_NONE;
        end
      end
      PS_PRESSED: begin
        if (!pressed) begin
          btn_event[b] = EV_UP;
          btn_ticks[b] = '0;
          btn_state[b] = PS_WAIT;
        end else if (btn_ticks[b] > long_lim) begin
          btn_event[b] = EV_LONG_START;
          act          = ACT_LONG;
          btn_state[b] = PS_HOLD;
        end
      end
      PS_WAIT: begin
        if (pressed) begin
          btn_event[b]   = EV_DOWN;
          btn_repeats[b] = btn_repeats[b] + 4'd1;
          if (btn_repeats[b] == 4'd2) act = ACT_DOUBLE;
          btn_ticks[b] = '0;
          btn_state[b] = PS_AGAIN;
        end else if (btn_ticks[b] > short_lim) begin
          if (btn_repeats[b] == 4'd1) begin
            btn_event[b] = EV_SINGLE;
            act          = ACT_SHORT;
          end else if (btn_repeats[b] == 4'd2) begin
            btn_event[b] = EV_DOUBLE;
          end
          btn_state[b] = PS_IDLE;
        end
      end
      PS_AGAIN: begin
        if (!pressed) begin
          btn_event[b] = EV_UP;
          if (btn_ticks[b] < short_lim) begin
            btn_ticks[b] = '0;
            btn_state[b] = PS_WAIT;
          end else begin
            btn_state[b] = PS_IDLE;
          end
        end
      end
      PS_HOLD: begin
        if (pressed) begin
          btn_event[b] = EV_LONG_HOLD;
        end else begin
          btn_event[b] = EV_UP;
          btn_state[b] = PS_IDLE;
        end
      end
      default: ;
    endcase
    r.event_code = btn_event[b];
    r.action     = act;
    return r;
  endfunction

  function automatic step_row_t cfg_row(input reg_idx_e idx, input logic [31:0] value);
    step_row_t s;
    s = '{1'b1, idx, value, '0, 1'b0, '0};
    return s;
  endfunction

  function automatic step_row_t tick_row(input logic op, input int b, input logic lvl);
    step_row_t s;
    s = '{1'b0, REG_DEBOUNCE, '0, '{op, 5'(b), lvl}, 1'b0, '0};
    return s;
  endfunction

  function automatic step_row_t want_row(input logic op, input int b, input logic lvl,
                                        input event_e ev, input act_e act);
    step_row_t s;
    s = '{1'b0, REG_DEBOUNCE, '0, '{op, 5'(b), lvl}, 1'b1, '{5'(b), ev, act}};
    return s;
  endfunction

  function automatic int clamp_run(input int n, input int top);
    return (n > top) ? top : ((n < 1) ? 1 : n);
  endfunction

  // Run lengths: debounce glitches, short clicks, long presses, timeouts.
  function automatic int pick_run();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return $urandom_range(clamp_run(dbnc_ticks, 8), 1);
    if (roll < 70) return $urandom_range(clamp_run(short_lim + dbnc_ticks + 2, 40), 1);
    if (roll < 85) return clamp_run(long_lim + dbnc_ticks + 1, 260) + $urandom_range(3);
    return clamp_run(short_lim + dbnc_ticks + 2, 40) + $urandom_range(4);
  endfunction

  // Entered and left at a falling edge; valid stays high for a following item.
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t guess;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    guess = next_button_event(it);
    pending_events.push_back(typed ? want : guess);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_DEBOUNCE: dbnc_ticks  = value[2:0];
      REG_SHORT:    short_lim   = value[15:0];
      REG_LONG:     long_lim    = value[15:0];
      REG_ACTIVE:   press_level = value[0];
      REG_INVERT:   invert_bits = value;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_config(input cfg_t c);
    settle();
    apb_write(REG_DEBOUNCE, 32'(c.debounce_ticks));
    apb_write(REG_SHORT, 32'(c.short_ticks));
    apb_write(REG_LONG, 32'(c.long_ticks));
    apb_write(REG_ACTIVE, 32'(c.press_polarity));
    apb_write(REG_INVERT, c.invert_mask);
    apb_release();
    settings_loaded++;
  endtask

  // Interleaved press/release gestures on a few buttons, plus init and stray samples.
  task automatic run_gestures(input int n_items);
    int       b;
    int       roll;
    in_item_t it;
    b = focus[0];
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        it = '{OP_INIT, 5'($urandom), 1'($urandom)};
      end else if (roll < 10) begin
        it = '{OP_TICK, 5'($urandom), 1'($urandom)};
      end else begin
        if ($urandom_range(99) >= 70) b = focus[$urandom_range(2)];
        if (run_left[b] == 0) begin
          drive_level[b] = ~drive_level[b];
          run_left[b] = pick_run();
        end
        run_left[b]--;
        it = '{OP_TICK, 5'(b), drive_level[b]};
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= gap_pct);

  always @(posedge clk_i) begin : check_events
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      events_seen++;
      if (pending_events.size() == 0) begin
        $error("result for button %0d with nothing expected", out_data_o.button_number);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (out_data_o.button_number !== want.button_number) begin
          $error("button_number: expected %0d, got %0d",
                 want.button_number, out_data_o.button_number);
          mismatches++;
        end
        if (out_data_o.event_code !== want.event_code) begin
          $error("event_code: expected %0d, got %0d", want.event_code, out_data_o.event_code);
          mismatches++;
        end
        if (out_data_o.action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, out_data_o.action);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    cfg_t plan [8];
    clear_buttons();

    // Uninitialized buttons read as pressed while the press polarity matches the reset level.
    script = '{
      want_row(OP_TICK, 0, 1'b0, EV_DOWN, ACT_NONE),
      want_row(OP_INIT, 1, 1'b1, EV_NONE, ACT_NONE),
      want_row(OP_TICK, 1, 1'b1, EV_NONE, ACT_NONE),
      cfg_row(REG_DEBOUNCE, 32'd0),
      cfg_row(REG_SHORT, 32'd2),
      cfg_row(REG_LONG, 32'd2),
      cfg_row(REG_ACTIVE, 32'd1),
      cfg_row(REG_INVERT, 32'h8000_0001),
      // long press on an inverted button
      want_row(OP_INIT, 31, 1'b0, EV_NONE, ACT_NONE),
      tick_row(OP_TICK, 31, 1'b0),
      tick_row(OP_TICK, 31, 1'b0),
      tick_row(OP_TICK, 31, 1'b0),
      tick_row(OP_TICK, 31, 1'b0),
      tick_row(OP_TICK, 31, 1'b0),
      tick_row(OP_TICK, 31, 1'b1),
      // single click, then timeout
      want_row(OP_INIT, 2, 1'b0, EV_NONE, ACT_NONE),
      tick_row(OP_TICK, 2, 1'b1),
      tick_row(OP_TICK, 2, 1'b0),
      tick_row(OP_TICK, 2, 1'b0),
      tick_row(OP_TICK, 2, 1'b0),
      tick_row(OP_TICK, 2, 1'b0),
      // double click, then timeout
      want_row(OP_INIT, 3, 1'b0, EV_NONE, ACT_NONE),
      tick_row(OP_TICK, 3, 1'b1),
      tick_row(OP_TICK, 3, 1'b0),
      tick_row(OP_TICK, 3, 1'b1),
      tick_row(OP_TICK, 3, 1'b0),
      tick_row(OP_TICK, 3, 1'b0),
      tick_row(OP_TICK, 3, 1'b0),
      tick_row(OP_TICK, 3, 1'b0)
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_write) begin
        settle();
        apb_write(script[i].reg_sel, script[i].value);
        apb_release();
      end else begin
        send_item(script[i].item, script[i].typed, script[i].want);
      end
    end
    settings_loaded++;

    plan[0] = CFG_RESET;
    plan[1] = '{3'd7, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF};
    plan[2] = '{3'd0, 16'd0, 16'd0, 1'b0, $urandom};
    for (int p = 3; p < 8; p++) begin
      plan[p] = '{3'($urandom), 16'($urandom_range(12)), 16'($urandom_range(24)),
                  1'($urandom), $urandom};
    end

    for (int p = 0; p < 8; p++) begin
      load_config(plan[p]);
      gap_pct = (p == 3) ? 0 : 37;
      focus[0] = (p == 0) ? 0 : $urandom_range(31);
      focus[1] = (p == 0) ? 31 : $urandom_range(31);
      focus[2] = $urandom_range(31);
      run_gestures(240);
    end

    gap_pct = 37;
    settle();
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d input and %0d result transactions over %0d register settings,",
             items_sent, events_seen, settings_loaded);
    $display("with clicks, double clicks, long presses, inits and stray samples.");
    if (mismatches == 0) begin
      $display("button_click_event_detector_top verification clean");
    end else begin
      $display("button_click_event_detector_top verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(CYCLE_NS * 1_000_000);
    $display("button_click_event_detector_top verification failed");
    $finish;
  end

endmodule
